/* hw/rtl/fltw_pkg.sv */
// Package for the four-level page table walker: status codes, level codes,
// register indexes and the address constants of the walk.
// No dependencies.
`timescale 1ns / 1ps

package fltw_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    StFetch   = 3'd0,
    StDone    = 3'd1,
    StAbsent  = 3'd2,
    StRange   = 3'd3,
    StIgnored = 3'd4
  } status_e;

  // Page kinds reported on completion
  typedef enum logic [1:0] {
    Kind4k = 2'd0,
    Kind2m = 2'd1,
    Kind1g = 2'd2
  } page_kind_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] RegPhysWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHoleEn    = 1'b1;

  // Walk level: idle, or waiting for the entry of table level 4..1
  localparam logic [2:0] LvlIdle = 3'd0;
  localparam logic [2:0] Lvl1    = 3'd1;
  localparam logic [2:0] Lvl2    = 3'd2;
  localparam logic [2:0] Lvl3    = 3'd3;
  localparam logic [2:0] Lvl4    = 3'd4;

  // Field widths
  localparam int unsigned PaW    = 52;
  localparam int unsigned VaW    = 48;
  localparam int unsigned FrameW = 40;
  localparam int unsigned BytesW = 31;

  // Page sizes and the optional address hole
  localparam logic [BytesW-1:0] Size4k    = 31'h0000_1000;
  localparam logic [BytesW-1:0] Size2m    = 31'h0020_0000;
  localparam logic [BytesW-1:0] Size1g    = 31'h4000_0000;
  localparam logic [PaW:0]      HoleLow   = 53'h00_00FD_0000_0000;
  localparam logic [PaW:0]      HoleHigh  = 53'h00_00FF_FFFF_FFFF;
  localparam logic [5:0]        MinLimitW = 6'd13;
  localparam logic [5:0]        ResetPaW  = 6'd48;

endpackage

/* hw/rtl/four_level_page_table_walker_core.sv */
// Four-level page table walker core: input stage, walk logic, result stage.
// Depends on fltw_pkg.
`timescale 1ns / 1ps

// A mode 0 transfer starts a walk (and drops any walk in flight); each mode 1
// transfer hands back the entry read at the last fetch_address_o. Every input
// transfer yields exactly one result transfer: a fetch request for the next
// entry, the finished translation (4 KB, 2 MB or 1 GB page), or a failure
// status. An item passes from input to result through the input register and
// then the result register, and one item is taken per cycle; throughput is set by
// the result register only, which keeps taking items whenever its result is
// consumed or it is empty. Configuration writes are taken in any cycle and
// must only happen while no walk item is in the pipeline.
module four_level_page_table_walker_core
  import fltw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [FrameW-1:0]   root_frame_i,
  input  logic [VaW-1:0]      virtual_address_i,
  input  logic [63:0]         table_entry_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [PaW-1:0]      fetch_address_o,
  output logic [PaW-1:0]      translated_address_o,
  output logic [BytesW-1:0]   bytes_to_page_end_o,
  output logic [1:0]          page_kind_o
);

  // Range check of a region: above the physical width, or touching the hole
  function automatic logic range_bad(logic [PaW-1:0] base, logic [BytesW-1:0] size,
                                     logic [5:0] aw, logic hole_en);
    logic [PaW:0] last;
    logic         over;
    logic         in_hole;
    last    = {1'b0, base} + (PaW+1)'(size) - (PaW+1)'(1);
    over    = (aw >= MinLimitW) && ((last >> aw) != '0);
    in_hole = hole_en && (last >= HoleLow) && ({1'b0, base} <= HoleHigh);
    return over || in_hole;
  endfunction

  // 9-bit table index of a level from the virtual address
  function automatic logic [8:0] level_index(logic [VaW-1:0] va, logic [2:0] lvl);
    logic [8:0] idx;
    case (lvl)
      Lvl4:    idx = va[47:39];
      Lvl3:    idx = va[38:30];
      Lvl2:    idx = va[29:21];
      Lvl1:    idx = va[20:12];
      default: idx = '0;
    endcase
    return idx;
  endfunction

  // Configuration registers
  logic [5:0] pa_width_q;
  logic       hole_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_width_q <= ResetPaW;
      hole_en_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPhysWidth: pa_width_q <= cfg_data_i;
        RegHoleEn:    hole_en_q  <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // Pipeline handshake
  logic in_valid_q;
  logic out_valid_q;
  logic advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  logic              mode_q;
  logic [FrameW-1:0] root_q;
  logic [VaW-1:0]    va_q;
  logic [63:0]       entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q  <= mode_i;
      root_q  <= root_frame_i;
      va_q    <= virtual_address_i;
      entry_q <= table_entry_i;
    end
  end

  // Walk state
  logic [2:0]     walk_q, walk_d;
  logic [VaW-1:0] held_q, held_d;

  // Walk logic
  logic [2:0]        status_d;
  logic [PaW-1:0]    fetch_d;
  logic [PaW-1:0]    phys_d;
  logic [BytesW-1:0] bytes_d;
  logic [1:0]        kind_d;

  logic [PaW-1:0]    tbl_base;
  logic [2:0]        tbl_lvl;
  logic [VaW-1:0]    tbl_va;
  logic              to_table;
  logic              to_finish;
  logic [PaW-1:0]    fin_base;
  logic [BytesW-1:0] fin_size;
  logic [29:0]       fin_off;
  logic [1:0]        fin_kind;
  logic              present;
  logic              big_page;

  always_comb begin
    walk_d    = walk_q;
    held_d    = held_q;
    status_d  = StIgnored;
    fetch_d   = '0;
    phys_d    = '0;
    bytes_d   = '0;
    kind_d    = '0;
    to_table  = 1'b0;
    to_finish = 1'b0;
    tbl_base  = {entry_q[51:12], 12'h000};
    tbl_lvl   = walk_q - 3'd1;
    tbl_va    = held_q;
    fin_base  = {entry_q[51:12], 12'h000};
    fin_size  = Size4k;
    fin_off   = {18'h0, held_q[11:0]};
    fin_kind  = Kind4k;
    present   = entry_q[0];
    big_page  = entry_q[7];

    if (!mode_q) begin
      // new walk from the top table
      held_d   = va_q;
      tbl_base = {root_q, 12'h000};
      tbl_lvl  = Lvl4;
      tbl_va   = va_q;
      to_table = 1'b1;
    end else if (walk_q < Lvl1 || walk_q > Lvl4) begin
      walk_d   = LvlIdle;
      status_d = StIgnored;
    end else if (!present) begin
      walk_d   = LvlIdle;
      status_d = StAbsent;
    end else if (walk_q == Lvl3 && big_page) begin
      to_finish = 1'b1;
      fin_base  = {entry_q[51:30], 30'h0};
      fin_size  = Size1g;
      fin_off   = held_q[29:0];
      fin_kind  = Kind1g;
    end else if (walk_q == Lvl2 && big_page) begin
      to_finish = 1'b1;
      fin_base  = {entry_q[51:21], 21'h0};
      fin_size  = Size2m;
      fin_off   = {9'h0, held_q[20:0]};
      fin_kind  = Kind2m;
    end else if (walk_q == Lvl1) begin
      to_finish = 1'b1;
    end else begin
      to_table = 1'b1;
    end

    // request the next entry after checking the table base
    if (to_table) begin
      if (range_bad(tbl_base, Size4k, pa_width_q, hole_en_q)) begin
        walk_d   = LvlIdle;
        status_d = StRange;
      end else begin
        walk_d   = tbl_lvl;
        status_d = StFetch;
        fetch_d  = {tbl_base[PaW-1:12], level_index(tbl_va, tbl_lvl), 3'b000};
      end
    end

    // final page: check and report
    if (to_finish) begin
      walk_d = LvlIdle;
      if (range_bad(fin_base, fin_size, pa_width_q, hole_en_q)) begin
        status_d = StRange;
      end else begin
        status_d = StDone;
        phys_d   = fin_base | {22'h0, fin_off};
        bytes_d  = fin_size - {1'b0, fin_off};
        kind_d   = fin_kind;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= LvlIdle;
      held_q <= '0;
    end else if (advance) begin
      walk_q <= walk_d;
      held_q <= held_d;
    end
  end

  // Result register
  logic [2:0]        status_q;
  logic [PaW-1:0]    fetch_q;
  logic [PaW-1:0]    phys_q;
  logic [BytesW-1:0] bytes_q;
  logic [1:0]        kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      fetch_q  <= fetch_d;
      phys_q   <= phys_d;
      bytes_q  <= bytes_d;
      kind_q   <= kind_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign fetch_address_o      = fetch_q;
  assign translated_address_o = phys_q;
  assign bytes_to_page_end_o  = bytes_q;
  assign page_kind_o          = kind_q;

endmodule
